>>> hdl/srsg_pkg.sv
// shared types and constants for the stepper ramp step generator
// used by every module of the block; depends on nothing
package srsg_pkg;

    localparam int unsigned TICK_RATE_DEF        = 8000;
    localparam int unsigned CONTROL_PRESCALE_DEF = 7;

    localparam int POS_W      = 32;
    localparam int GAIN_W     = 16;
    localparam int RATE_W     = 20;
    localparam int HDIST_W    = 31;
    localparam int PERIOD_W   = 14;
    localparam int CNT_W      = 16;
    localparam int TICK_W     = 16;
    localparam int DIV_CNT_W  = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 31;
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_TARGET = 2'd1,
        OP_HOME   = 2'd2,
        OP_POWER  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MV_NONE  = 2'd0,
        MV_PLUS  = 2'd1,
        MV_MINUS = 2'd3
    } t_move;

    typedef enum logic [1:0] {
        HS_OFF    = 2'd0,
        HS_SEARCH = 2'd1,
        HS_FOUND  = 2'd2,
        HS_ON     = 2'd3
    } t_home;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ACCEL_GAIN = 3'd0,
        REG_DECEL_GAIN = 3'd1,
        REG_MAX_RATE   = 3'd2,
        REG_MIN_RATE   = 3'd3,
        REG_HOME_DIST  = 3'd4
    } t_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL_DEC,
        ST_MUL_ACC,
        ST_RATE,
        ST_DIV,
        ST_PERIOD,
        ST_EXEC,
        ST_POST
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_dec;
        logic mul_acc;
        logic rate;
        logic div_step;
        logic period;
        logic exec;
        logic post;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic ctrl_due;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

>>> hdl/srsg_ctrl.sv
// sequencing state machine of the stepper ramp step generator
// depends on srsg_pkg; drives the datapath through t_cmd, reads t_status
module srsg_ctrl
    import srsg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_status.is_tick && i_status.ctrl_due) begin
                    n_state = ST_MUL_DEC;
                end else begin
                    n_state = ST_EXEC;
                end
            end
            ST_MUL_DEC: begin
                o_cmd.mul_dec = 1'b1;
                n_state       = ST_MUL_ACC;
            end
            ST_MUL_ACC: begin
                o_cmd.mul_acc = 1'b1;
                n_state       = ST_RATE;
            end
            ST_RATE: begin
                o_cmd.rate = 1'b1;
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_PERIOD;
                end
            end
            ST_PERIOD: begin
                o_cmd.period = 1'b1;
                n_state      = ST_EXEC;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_POST;
            end
            ST_POST: begin
                if (i_status.out_free) begin
                    o_cmd.post = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/srsg_div.sv
// restoring divider, one quotient bit per step, for tick rate over step rate
// depends on srsg_pkg; used by srsg_dp
module srsg_div
    import srsg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_init,
    input  logic              i_step,
    input  logic [TICK_W-1:0] i_dividend,
    input  logic [RATE_W-1:0] i_divisor,
    output logic [TICK_W-1:0] o_quotient,
    output logic              o_last
);

    logic [TICK_W-1:0]    r_quo;
    logic [RATE_W-1:0]    r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [RATE_W:0]      rem_sh;
    logic [RATE_W:0]      rem_sub;
    logic                 fits;

    assign rem_sh  = {r_rem, r_quo[TICK_W-1]};
    assign fits    = rem_sh >= {1'b0, i_divisor};
    assign rem_sub = rem_sh - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_init) begin
            r_cnt <= '0;
        end else if (i_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (i_step) begin
            r_quo <= {r_quo[TICK_W-2:0], fits};
            r_rem <= fits ? rem_sub[RATE_W-1:0] : rem_sh[RATE_W-1:0];
        end
    end

    assign o_quotient = r_quo;
    assign o_last     = r_cnt == DIV_CNT_W'(TICK_W - 1);

endmodule

>>> hdl/srsg_dp.sv
// datapath: configuration, motion state, shared multiplier, rate clamp, output register
// depends on srsg_pkg and srsg_div; controlled by srsg_ctrl
module srsg_dp
    import srsg_pkg::*;
#(
    parameter int unsigned TICK_RATE        = TICK_RATE_DEF,
    parameter int unsigned CONTROL_PRESCALE = CONTROL_PRESCALE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic [IN_USER_W-1:0]  i_in_user,
    input  logic                  i_out_ready,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_out_valid,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    localparam logic [TICK_W-1:0] TICK_VAL  = TICK_W'(TICK_RATE);
    localparam logic [CNT_W-1:0]  PRESC_VAL = CNT_W'(CONTROL_PRESCALE);

    logic [GAIN_W-1:0]  r_accel_gain;
    logic [GAIN_W-1:0]  r_decel_gain;
    logic [RATE_W-1:0]  r_max_rate;
    logic [RATE_W-1:0]  r_min_rate;
    logic [HDIST_W-1:0] r_home_dist;

    t_op                r_op;
    logic [POS_W-1:0]   r_tgt;
    logic               r_hdir;
    logic               r_pwr;
    logic               r_sw;

    logic [POS_W-1:0]    r_cur;
    logic [POS_W-1:0]    r_tar;
    logic [POS_W-1:0]    r_rest;
    t_move               r_move_dir;
    logic [PERIOD_W-1:0] r_step_period;
    logic [CNT_W-1:0]    r_step_count;
    logic [CNT_W-1:0]    r_control_count;
    t_home               r_homing;
    logic                r_power_dis;
    logic                r_dir_pin;
    logic                r_pulse;

    logic [POS_W-1:0]  r_tv;
    logic [POS_W-1:0]  r_ov;
    logic [RATE_W-1:0] r_rate;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [GAIN_W-1:0]       mul_gain;
    logic [POS_W-1:0]        mul_dist;
    logic [GAIN_W+POS_W-1:0] mul_full;

    logic [POS_W-1:0]  dec_rate;
    logic [POS_W-1:0]  acc_rate;
    logic [POS_W-1:0]  rate_min;
    logic [POS_W-1:0]  rate_hi;
    logic [POS_W-1:0]  rate_lo;
    t_move             dir_sel;

    logic [TICK_W-1:0] quotient;
    logic              div_last;

    logic [POS_W-1:0]  home_tar;

    logic              moving;
    logic [POS_W-1:0]  post_cur;
    logic [POS_W-1:0]  post_tar;
    t_home             post_home;
    logic              out_free;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_gain <= '0;
            r_decel_gain <= '0;
            r_max_rate   <= RATE_W'(1);
            r_min_rate   <= RATE_W'(1);
            r_home_dist  <= '0;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_addr))
                REG_ACCEL_GAIN: r_accel_gain <= i_cfg_data[GAIN_W-1:0];
                REG_DECEL_GAIN: r_decel_gain <= i_cfg_data[GAIN_W-1:0];
                REG_MAX_RATE:   r_max_rate   <= i_cfg_data[RATE_W-1:0];
                REG_MIN_RATE:   r_min_rate   <= i_cfg_data[RATE_W-1:0];
                REG_HOME_DIST:  r_home_dist  <= i_cfg_data[HDIST_W-1:0];
                default: ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_in_user);
            r_tgt  <= i_in_data[POS_W-1:0];
            r_hdir <= i_in_data[POS_W];
            r_pwr  <= i_in_data[POS_W+1];
            r_sw   <= i_in_data[POS_W+2];
        end
    end

    // shared multiplier, product wraps at the position width
    assign mul_gain = i_cmd.mul_dec ? r_decel_gain : r_accel_gain;
    assign mul_dist = i_cmd.mul_dec ? (r_tar - r_cur) : (r_cur - r_rest);
    assign mul_full = mul_gain * mul_dist;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_dec) begin
            r_tv <= mul_full[POS_W-1:0];
        end
        if (i_cmd.mul_acc) begin
            r_ov <= mul_full[POS_W-1:0];
        end
    end

    // direction, smaller rate, clamps
    always_comb begin
        if (r_tv == '0) begin
            dir_sel  = MV_NONE;
            dec_rate = '0;
            acc_rate = '0;
        end else if (!r_tv[POS_W-1]) begin
            dir_sel  = MV_PLUS;
            dec_rate = r_tv;
            acc_rate = r_ov;
        end else begin
            dir_sel  = MV_MINUS;
            dec_rate = -r_tv;
            acc_rate = -r_ov;
        end
        rate_min = (dec_rate < acc_rate) ? dec_rate : acc_rate;
        rate_hi  = (rate_min > POS_W'(r_max_rate)) ? POS_W'(r_max_rate) : rate_min;
        rate_lo  = (rate_hi < POS_W'(r_min_rate)) ? POS_W'(r_min_rate) : rate_hi;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rate) begin
            r_rate <= rate_lo[RATE_W-1:0];
        end
    end

    srsg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_init     (i_cmd.rate),
        .i_step     (i_cmd.div_step),
        .i_dividend (TICK_VAL),
        .i_divisor  (r_rate),
        .o_quotient (quotient),
        .o_last     (div_last)
    );

    assign home_tar = r_hdir ? {1'b0, r_home_dist} : -{1'b0, r_home_dist};

    // end of item: position indicator and homing progress
    always_comb begin
        post_cur  = r_cur;
        post_tar  = r_tar;
        post_home = r_homing;
        moving    = r_cur != r_tar;
        if (!moving && r_homing == HS_FOUND) begin
            post_home = HS_ON;
            post_cur  = '0;
            post_tar  = '0;
        end
        if (post_home == HS_SEARCH && r_sw) begin
            post_tar  = post_cur;
            post_home = HS_FOUND;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    // motion state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur           <= '0;
            r_tar           <= '0;
            r_rest          <= '0;
            r_move_dir      <= MV_NONE;
            r_step_period   <= '0;
            r_step_count    <= '0;
            r_control_count <= '0;
            r_homing        <= HS_OFF;
            r_power_dis     <= 1'b1;
            r_dir_pin       <= 1'b0;
            r_pulse         <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_pulse <= 1'b0;
            end
            if (i_cmd.rate) begin
                r_move_dir <= dir_sel;
            end
            if (i_cmd.period) begin
                r_step_period <= (quotient > TICK_W'(PERIOD_MAX)) ? PERIOD_MAX
                                                                  : quotient[PERIOD_W-1:0];
            end
            if (i_cmd.exec) begin
                case (r_op)
                    OP_TARGET: begin
                        r_tar    <= r_tgt;
                        r_homing <= HS_OFF;
                    end
                    OP_HOME: begin
                        r_tar    <= home_tar;
                        r_homing <= HS_SEARCH;
                    end
                    OP_POWER: begin
                        r_cur       <= '0;
                        r_tar       <= '0;
                        r_rest      <= '0;
                        r_homing    <= HS_OFF;
                        r_power_dis <= !r_pwr;
                    end
                    default: begin
                        if (r_control_count >= PRESC_VAL) begin
                            r_control_count <= '0;
                        end else begin
                            r_control_count <= r_control_count + 1'b1;
                        end
                        if (r_step_count >= CNT_W'(r_step_period)) begin
                            r_step_count <= '0;
                            if (r_move_dir == MV_PLUS) begin
                                r_dir_pin <= 1'b0;
                                r_cur     <= r_cur + 1'b1;
                                r_pulse   <= 1'b1;
                            end else if (r_move_dir == MV_MINUS) begin
                                r_dir_pin <= 1'b1;
                                r_cur     <= r_cur - 1'b1;
                                r_pulse   <= 1'b1;
                            end
                        end else begin
                            r_step_count <= r_step_count + 1'b1;
                        end
                    end
                endcase
            end
            if (i_cmd.post) begin
                r_cur    <= post_cur;
                r_tar    <= post_tar;
                r_homing <= post_home;
                if (!moving) begin
                    r_rest <= post_cur;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.post) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.post) begin
            r_out_data <= {(OUT_DATA_W - POS_W - 5)'(0), post_cur, r_power_dis,
                           post_home == HS_ON, moving, r_dir_pin, r_pulse};
        end
    end

    assign o_status.is_tick  = r_op == OP_TICK;
    assign o_status.ctrl_due = r_control_count >= PRESC_VAL;
    assign o_status.div_last = div_last;
    assign o_status.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> hdl/stepper_ramp_step_generator.sv
// Tick-driven stepper position controller with step/direction outputs and a
// distance-based rate ramp. One item is handled at a time: a command or a plain
// tick goes from acceptance through decode, execute and post to the result
// register; a tick that runs the control update (every CONTROL_PRESCALE+1 ticks)
// also makes two passes through the shared multiplier and runs the 16-step
// restoring divider that forms TICK_RATE over the clamped rate. The next item is
// taken in the cycle after the current one has been written to the result
// register; a waiting result holds the block in its final step until it is
// taken.
// top level: depends on srsg_pkg, srsg_ctrl, srsg_dp, srsg_div
module stepper_ramp_step_generator
    import srsg_pkg::*;
#(
    parameter int unsigned TICK_RATE        = TICK_RATE_DEF,
    parameter int unsigned CONTROL_PRESCALE = CONTROL_PRESCALE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // target_pos[31:0], home_dir[32], power_on[33], home_switch[34], zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op[1:0]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // step_pulse[0], direction[1], moving[2], homed[3], enable_n[4],
    // current_pos[36:5], zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_cmd    cmd;
    t_status status;

    srsg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    srsg_dp #(
        .TICK_RATE        (TICK_RATE),
        .CONTROL_PRESCALE (CONTROL_PRESCALE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for stepper_ramp_step_generator: a directed table, then random moves,
// homing runs, power commands and random ops, each result checked against the table's want
// or an in-bench ramp model; depends on srsg_pkg and the stepper_ramp_step_generator rtl
module tb_top;
    import srsg_pkg::*;

    typedef struct packed {
        t_op         op;
        logic        home_switch;
        logic        power_on;
        logic        home_dir;
        logic [31:0] target;
    } cmd_item_t;

    // same bit order as m_axis_tdata[36:0]
    typedef struct packed {
        logic [31:0] current_pos;
        logic        enable_n;
        logic        homed;
        logic        moving;
        logic        direction;
        logic        step_pulse;
    } motor_out_t;

    typedef struct packed {
        cmd_item_t  cmd;
        logic       typed;
        motor_out_t want;
    } dir_row_t;

    typedef struct packed {
        logic [15:0] acc;
        logic [15:0] dec;
        logic [19:0] rmax;
        logic [19:0] rmin;
        logic [30:0] hdist;
        logic        gaps;
    } phase_cfg_t;

    localparam int N_DIR       = 24;
    localparam int N_PHASE     = 6;
    localparam int RAND_PHASE  = 4;
    localparam int PHASE_ITEMS = 160;
    localparam int SETTLE_CYC  = 30;

    localparam motor_out_t NO_WANT = '0;

    // columns: cmd (op, switch, power, home dir, target), typed, want
    // want: pos, enable_n, homed, moving, direction, step_pulse
    localparam dir_row_t DIR_TABLE [N_DIR] = '{
        '{'{OP_TICK, 1'b0, 1'b0, 1'b0, 32'h0}, 1'b1,
          '{32'h0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_POWER, 1'b0, 1'b1, 1'b0, 32'h0}, 1'b1,
          '{32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_TARGET, 1'b1, 1'b0, 1'b0, 32'h7FFF_FFFF}, 1'b1,
          '{32'h0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{'{OP_TICK, 1'b0, 1'b0, 1'b0, 32'h0}, 1'b0, NO_WANT},
        '{'{OP_TARGET, 1'b0, 1'b0, 1'b0, 32'h8000_0000}, 1'b1,
          '{32'h0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{'{OP_TARGET, 1'b0, 1'b0, 1'b0, 32'h0}, 1'b1,
          '{32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_HOME, 1'b0, 1'b0, 1'b1, 32'h0}, 1'b1,
          '{32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_TICK, 1'b1, 1'b0, 1'b0, 32'h0}, 1'b0, NO_WANT},
        '{'{OP_TICK, 1'b0, 1'b0, 1'b0, 32'h0}, 1'b0, NO_WANT},
        '{'{OP_HOME, 1'b1, 1'b0, 1'b0, 32'h0}, 1'b1,
          '{32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_TICK, 1'b0, 1'b0, 1'b0, 32'h0}, 1'b0, NO_WANT},
        '{'{OP_POWER, 1'b0, 1'b0, 1'b0, 32'h0}, 1'b1,
          '{32'h0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_TARGET, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF}, 1'b0, NO_WANT},
        '{'{OP_TICK, 1'b0, 1'b0, 1'b0, 32'h0}, 1'b0, NO_WANT},
        '{'{OP_TICK, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF}, 1'b0, NO_WANT},
        '{'{OP_TICK, 1'b0, 1'b0, 1'b0, 32'h0}, 1'b0, NO_WANT},
        '{'{OP_TICK, 1'b0, 1'b0, 1'b0, 32'h0}, 1'b0, NO_WANT},
        '{'{OP_TICK, 1'b0, 1'b0, 1'b0, 32'h0}, 1'b0, NO_WANT},
        '{'{OP_TICK, 1'b0, 1'b0, 1'b0, 32'h0}, 1'b0, NO_WANT},
        '{'{OP_TICK, 1'b0, 1'b0, 1'b0, 32'h0}, 1'b0, NO_WANT},
        '{'{OP_TICK, 1'b0, 1'b0, 1'b0, 32'h0}, 1'b0, NO_WANT},
        '{'{OP_TICK, 1'b0, 1'b0, 1'b0, 32'h0}, 1'b0, NO_WANT},
        '{'{OP_TICK, 1'b0, 1'b0, 1'b0, 32'h0}, 1'b0, NO_WANT},
        '{'{OP_POWER, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF}, 1'b0, NO_WANT}
    };

    // gains, rate clamps, home travel, idling on
    localparam phase_cfg_t PHASES [N_PHASE] = '{
        '{16'd300, 16'd400, 20'd8000, 20'd2000, 31'd25, 1'b1},
        '{16'd65535, 16'd65535, 20'd1048575, 20'd1, 31'd2147483647, 1'b1},
        '{16'd0, 16'd1, 20'd1, 20'd1048575, 31'd0, 1'b0},
        '{16'd65535, 16'd1, 20'd1048575, 20'd8000, 31'd2147483647, 1'b1},
        '{16'd0, 16'd0, 20'd1, 20'd1, 31'd0, 1'b1},
        '{16'd7, 16'd3, 20'd4000, 20'd2500, 31'd40, 1'b0}
    };

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // ramp model state, reset values
    logic [31:0] m_cur      = '0;
    logic [31:0] m_tar      = '0;
    logic [31:0] m_rest     = '0;
    t_move       m_dir      = MV_NONE;
    logic [31:0] m_period   = '0;
    logic [31:0] m_step_cnt = '0;
    logic [31:0] m_ctrl_cnt = '0;
    t_home       m_home     = HS_OFF;
    logic        m_pwr_dis  = 1'b1;
    logic        m_dir_pin  = 1'b0;

    logic [31:0] g_acc  = '0;
    logic [31:0] g_dec  = '0;
    logic [31:0] r_max  = 32'd1;
    logic [31:0] r_min  = 32'd1;
    logic [31:0] h_dist = '0;

    motor_out_t pending_out [$];
    int         idle_max   = 4;
    int         items_sent = 0;
    int         err_count  = 0;

    stepper_ramp_step_generator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic motor_out_t motor_predict(input cmd_item_t c);
        motor_out_t  r;
        logic [31:0] tv, ov, r_dec, r_acc, rate, per;
        r = '0;
        case (c.op)
            OP_TARGET: begin
                m_tar  = c.target;
                m_home = HS_OFF;
            end
            OP_HOME: begin
                m_tar  = c.home_dir ? h_dist : 32'd0 - h_dist;
                m_home = HS_SEARCH;
            end
            OP_POWER: begin
                m_cur     = '0;
                m_tar     = '0;
                m_rest    = '0;
                m_home    = HS_OFF;
                m_pwr_dis = ~c.power_on;
            end
            default: begin
                if (m_ctrl_cnt >= CONTROL_PRESCALE_DEF) begin
                    m_ctrl_cnt = '0;
                    tv = g_dec * (m_tar - m_cur);
                    ov = g_acc * (m_cur - m_rest);
                    if (tv == '0) begin
                        m_dir = MV_NONE;
                        r_dec = '0;
                        r_acc = '0;
                    end else if (!tv[31]) begin
                        m_dir = MV_PLUS;
                        r_dec = tv;
                        r_acc = ov;
                    end else begin
                        m_dir = MV_MINUS;
                        r_dec = 32'd0 - tv;
                        r_acc = 32'd0 - ov;
                    end
                    rate = (r_dec < r_acc) ? r_dec : r_acc;
                    if (rate > r_max) rate = r_max;
                    if (rate < r_min) rate = r_min;
                    if (rate == '0) begin
                        per = 32'(PERIOD_MAX);
                    end else begin
                        per = TICK_RATE_DEF / rate;
                        if (per > 32'(PERIOD_MAX)) per = 32'(PERIOD_MAX);
                    end
                    m_period = per;
                end else begin
                    m_ctrl_cnt = m_ctrl_cnt + 32'd1;
                end
                if (m_step_cnt >= m_period) begin
                    m_step_cnt = '0;
                    if (m_dir != MV_NONE) begin
                        if (m_dir == MV_PLUS) begin
                            m_dir_pin = 1'b0;
                            m_cur     = m_cur + 32'd1;
                        end else begin
                            m_dir_pin = 1'b1;
                            m_cur     = m_cur - 32'd1;
                        end
                        r.step_pulse = 1'b1;
                    end
                end else begin
                    m_step_cnt = (m_step_cnt + 32'd1) & 32'h0000_FFFF;
                end
            end
        endcase
        if (m_cur != m_tar) begin
            r.moving = 1'b1;
        end else begin
            if (m_home == HS_FOUND) begin
                m_home = HS_ON;
                m_cur  = '0;
                m_tar  = '0;
            end
            m_rest = m_cur;
        end
        if (m_home == HS_SEARCH && c.home_switch) begin
            m_tar  = m_cur;
            m_home = HS_FOUND;
        end
        r.direction   = m_dir_pin;
        r.homed       = (m_home == HS_ON);
        r.enable_n    = m_pwr_dis;
        r.current_pos = m_cur;
        return r;
    endfunction

    function automatic cmd_item_t rand_tick(input logic sw);
        cmd_item_t c;
        c.op          = OP_TICK;
        c.home_switch = sw;
        c.power_on    = 1'($urandom_range(0, 1));
        c.home_dir    = 1'($urandom_range(0, 1));
        c.target      = $urandom;
        return c;
    endfunction

    task automatic drive_cmd(input cmd_item_t c, input logic typed, input motor_out_t want);
        int         gap;
        motor_out_t pred;
        gap = $urandom_range(0, idle_max);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({c.home_switch, c.power_on, c.home_dir, c.target});
        s_axis_tuser  <= c.op;
        do @(posedge i_clk); while (!(s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1));
        pred = motor_predict(c);
        pending_out.push_back(typed ? want : pred);
        items_sent++;
    endtask

    task automatic write_reg(input t_reg idx, input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_ACCEL_GAIN: g_acc = 32'(val[GAIN_W-1:0]);
            REG_DECEL_GAIN: g_dec = 32'(val[GAIN_W-1:0]);
            REG_MAX_RATE:   r_max = 32'(val[RATE_W-1:0]);
            REG_MIN_RATE:   r_min = 32'(val[RATE_W-1:0]);
            default:        h_dist = 32'(val[HDIST_W-1:0]);
        endcase
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        cmd_item_t   c;
        phase_cfg_t  pc;
        int          n, k, sel;
        logic [31:0] off;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < N_DIR; i++) begin
            drive_cmd(DIR_TABLE[i].cmd, DIR_TABLE[i].typed, DIR_TABLE[i].want);
        end
        for (int p = 0; p < N_PHASE; p++) begin
            s_axis_tvalid <= 1'b0;
            while (pending_out.size() != 0) @(posedge i_clk);
            repeat (SETTLE_CYC) @(posedge i_clk);
            pc = PHASES[p];
            if (p == RAND_PHASE) begin
                pc.acc   = 16'($urandom_range(0, 65535));
                pc.dec   = 16'($urandom_range(0, 65535));
                pc.rmax  = 20'($urandom_range(1, 1048575));
                pc.rmin  = 20'($urandom_range(1500, 1048575));
                pc.hdist = 31'($urandom_range(0, 200));
            end
            write_reg(REG_ACCEL_GAIN, CFG_DATA_W'(pc.acc));
            write_reg(REG_DECEL_GAIN, CFG_DATA_W'(pc.dec));
            write_reg(REG_MAX_RATE, CFG_DATA_W'(pc.rmax));
            write_reg(REG_MIN_RATE, CFG_DATA_W'(pc.rmin));
            write_reg(REG_HOME_DIST, CFG_DATA_W'(pc.hdist));
            i_cfg_we <= 1'b0;
            idle_max   = pc.gaps ? 4 : 0;
            items_sent = 0;
            while (items_sent < PHASE_ITEMS) begin
                sel = $urandom_range(0, 19);
                if (sel < 11) begin
                    // short move, then a run of ticks
                    off      = $urandom_range(1, 60);
                    c        = rand_tick($urandom_range(0, 15) == 0);
                    c.op     = OP_TARGET;
                    c.target = $urandom_range(0, 1) ? m_cur + off : m_cur - off;
                    drive_cmd(c, 1'b0, NO_WANT);
                    n = $urandom_range(10, 60);
                    repeat (n) drive_cmd(rand_tick($urandom_range(0, 15) == 0), 1'b0, NO_WANT);
                end else if (sel < 14) begin
                    // homing search, switch pressed once or never
                    c    = rand_tick(1'b0);
                    c.op = OP_HOME;
                    drive_cmd(c, 1'b0, NO_WANT);
                    n = $urandom_range(5, 50);
                    k = $urandom_range(0, n + 20);
                    for (int j = 0; j < n + 10; j++) begin
                        drive_cmd(rand_tick(j == k), 1'b0, NO_WANT);
                    end
                end else if (sel < 16) begin
                    c    = rand_tick($urandom_range(0, 1) == 0);
                    c.op = OP_POWER;
                    drive_cmd(c, 1'b0, NO_WANT);
                    n = $urandom_range(0, 10);
                    repeat (n) drive_cmd(rand_tick(1'b0), 1'b0, NO_WANT);
                end else if (sel < 18) begin
                    // far target over the full range, distance products wrap
                    c    = rand_tick($urandom_range(0, 1) == 0);
                    c.op = OP_TARGET;
                    drive_cmd(c, 1'b0, NO_WANT);
                    n = $urandom_range(5, 20);
                    repeat (n) drive_cmd(rand_tick(1'b0), 1'b0, NO_WANT);
                end else begin
                    c    = rand_tick($urandom_range(0, 1) == 0);
                    c.op = t_op'($urandom_range(0, 3));
                    drive_cmd(c, 1'b0, NO_WANT);
                end
            end
        end
        s_axis_tvalid <= 1'b0;
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (err_count == 0) begin
            $display("stepper_ramp_step_generator regression: pass");
        end else begin
            $display("stepper_ramp_step_generator regression: fail");
        end
        $finish;
    end

    initial begin : result_check
        int         stall;
        motor_out_t got, want;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, idle_max);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1));
            got = m_axis_tdata[36:0];
            if (pending_out.size() == 0) begin
                $error("item out with nothing pending: %h", got);
                err_count++;
            end else begin
                want = pending_out.pop_front();
                if (got.step_pulse !== want.step_pulse) begin
                    $error("step_pulse expected %0d got %0d", want.step_pulse, got.step_pulse);
                    err_count++;
                end
                if (got.direction !== want.direction) begin
                    $error("direction expected %0d got %0d", want.direction, got.direction);
                    err_count++;
                end
                if (got.moving !== want.moving) begin
                    $error("moving expected %0d got %0d", want.moving, got.moving);
                    err_count++;
                end
                if (got.homed !== want.homed) begin
                    $error("homed expected %0d got %0d", want.homed, got.homed);
                    err_count++;
                end
                if (got.enable_n !== want.enable_n) begin
                    $error("enable_n expected %0d got %0d", want.enable_n, got.enable_n);
                    err_count++;
                end
                if (got.current_pos !== want.current_pos) begin
                    $error("current_pos expected %0d got %0d",
                           $signed(want.current_pos), $signed(got.current_pos));
                    err_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #(64'd20_000_000);
        $display("stepper_ramp_step_generator regression: fail");
        $finish;
    end

endmodule
